// ===== design/lpm_pkg.sv =====
// shared constants, polynomial table and inter-cell transfer type
// for the lfsr polynomial matcher; no dependencies
package lpm_pkg;

  localparam int POLY_TOTAL   = 35;
  localparam int WINDOW_COUNT = 12;
  localparam int WORD_W       = 32;
  localparam int POLY_W       = 20;
  localparam int INDEX_W      = 6;
  localparam int COUNT_W      = 4;

  // feedback polynomials, one per cell
  localparam logic [POLY_W-1:0] POLY_TABLE [POLY_TOTAL] = '{
    20'h1D258, 20'h17E04, 20'h1FF6B, 20'h13F67,
    20'h1B9EE, 20'h198D1, 20'h178C7, 20'h18A55,
    20'h15777, 20'h1D911, 20'h15769, 20'h1991F,
    20'h12BD0, 20'h1CF73, 20'h1365D, 20'h197F5,
    20'h194A0, 20'h1B279, 20'h13A34, 20'h1AE41,
    20'h180D4, 20'h17891, 20'h12E64, 20'h17C72,
    20'h19C6D, 20'h13F32, 20'h1AE14, 20'h14E76,
    20'h13C97, 20'h130CB, 20'h13750, 20'h1CB8D,
    20'hD3675, 20'h90C2D, 20'hAE6CB
  };

  // what one cell hands to the next
  typedef struct packed {
    logic               valid;
    logic [WORD_W-1:0]  word;
    logic [INDEX_W-1:0] best_index;
    logic [COUNT_W-1:0] best_count;
  } lpm_token_t;

endpackage

// ===== design/lpm_cell.sv =====
// one cell of the matcher chain: scores the word against one polynomial
// and keeps the running best; uses lpm_pkg
module lpm_cell import lpm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [INDEX_W-1:0] cell_index,
  input  lpm_token_t         token_in,
  output lpm_token_t         token_out
);

  logic [POLY_W-1:0]       poly;
  logic [WINDOW_COUNT-1:0] zero_par;
  logic [COUNT_W-1:0]      count;
  logic                    better;

  assign poly = POLY_TABLE[cell_index];

  // parity of each shifted window against the polynomial
  always_comb begin
    for (int w = 0; w < WINDOW_COUNT; w++) begin
      zero_par[w] = ~(^((token_in.word >> w) & {{(WORD_W-POLY_W){1'b0}}, poly}));
    end
  end

  assign count  = COUNT_W'($countones(zero_par));
  assign better = count > token_in.best_count;

  // control bit under reset, payload free-running
  always_ff @(posedge clk) begin
    if (rst) begin
      token_out.valid <= 1'b0;
    end else begin
      token_out.valid <= token_in.valid;
    end
    token_out.word <= token_in.word;
    if (better) begin
      token_out.best_index <= cell_index;
      token_out.best_count <= count;
    end else begin
      token_out.best_index <= token_in.best_index;
      token_out.best_count <= token_in.best_count;
    end
  end

endmodule

// ===== design/lfsr_polynomial_matcher.sv =====
// top level of the lfsr polynomial matcher: a chain of lpm_cell instances
// depends on lpm_pkg and lpm_cell
//
// One 32-bit sweep word is taken on every clock where start is high; busy is
// never raised. The word walks through a chain of 35 cells, one per feedback
// polynomial, each adding one register stage. Its result is shown on
// best_index and match_count with result_valid high for exactly one cycle,
// once the word has passed the register of every cell. Results come out in
// input order, one per word, at up to one per cycle; the receiver must take
// each result in the cycle it is shown. Ties between polynomials go to the
// lowest index, and a word that scores zero everywhere reports index 0 with
// count 0.
module lfsr_polynomial_matcher import lpm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [WORD_W-1:0]  sample_word,
  output logic               result_valid,
  output logic [INDEX_W-1:0] best_index,
  output logic [COUNT_W-1:0] match_count
);

  lpm_token_t chain [POLY_TOTAL+1];

  assign busy = 1'b0;

  // chain entry: fresh word with an empty best
  assign chain[0].valid      = start;
  assign chain[0].word       = sample_word;
  assign chain[0].best_index = '0;
  assign chain[0].best_count = '0;

  // one cell per polynomial
  for (genvar i = 0; i < POLY_TOTAL; i++) begin : g_cell
    lpm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (INDEX_W'(i)),
      .token_in   (chain[i]),
      .token_out  (chain[i+1])
    );
  end

  // chain exit
  assign result_valid = chain[POLY_TOTAL].valid;
  assign best_index   = chain[POLY_TOTAL].best_index;
  assign match_count  = chain[POLY_TOTAL].best_count;

  // checks
  a_valid_follows_chain: assert property (@(posedge clk) disable iff (rst)
    chain[POLY_TOTAL-1].valid |=> result_valid)
    else $error("result strobe lost at end of chain");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (match_count <= COUNT_W'(WINDOW_COUNT)))
    else $error("match count beyond window count");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (best_index < INDEX_W'(POLY_TOTAL)))
    else $error("best index beyond table");

  a_zero_count_index: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (match_count == '0)) |-> (best_index == '0))
    else $error("zero count with nonzero index");

endmodule
